>>> rtl/core/sha_pkg.sv
// Shared types, constants and round functions for the streaming SHA-256 hasher.
package sha_pkg;

    localparam int BLOCK_WORDS = 16;
    localparam int HASH_WORDS  = 8;
    localparam int ROUNDS      = 64;
    localparam int BLOCK_BYTES = 64;
    localparam int LEN_LANE    = 56;
    localparam logic [7:0]  PAD_BYTE  = 8'h80;
    localparam logic [60:0] COUNT_MAX = '1;

    typedef struct packed {
        logic       action;
        logic [7:0] data_byte;
    } msg_req_t;

    typedef struct packed {
        logic [31:0] digest_word_0;
        logic [31:0] digest_word_1;
        logic [31:0] digest_word_2;
        logic [31:0] digest_word_3;
        logic [31:0] digest_word_4;
        logic [31:0] digest_word_5;
        logic [31:0] digest_word_6;
        logic [31:0] digest_word_7;
        logic        length_error;
    } digest_req_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       write_byte;
        logic       pad;
        logic       len;
        logic       load_work;
        logic       round;
        logic [5:0] round_idx;
        logic       update;
        logic       emit;
    } sha_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pos_last;
        logic pos_ge56;
    } sha_status_t;

    localparam logic [31:0] ROUND_K [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] INIT_H [HASH_WORDS] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

>>> rtl/core/sha_stream_if.sv
// Valid/ready stream channel with a typed payload.
interface sha_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/core/sha256_stream_hasher.sv
// Top level of the streaming SHA-256 hasher: controller plus datapath.
//
// Usage: each request on the msg channel is either an absorb (action 0), which adds
// data_byte to the message, or a finish (action 1), which pads the message, appends
// its bit length and delivers one digest request on the digest channel.
// The 64th byte of a block starts a compression of 64 rounds through a single round
// unit and then the chaining add; msg.ready is low throughout.
// A finish runs one compression, or two when the pad byte lands in the last eight
// byte positions of the block and a second length block is needed; the digest is
// valid on the cycle after the final chaining add.
// The digest sits in an output register: more bytes of the next message are taken
// while it waits, but the next finish is held off until the receiver takes it.
// length_error flags a message longer than 2^61-1 bytes; the digest is then invalid.
// After a finish the hash restarts from the initial values for a new message.
// Reset loads the initial hash values, clears the byte counter, the error flag and
// the digest valid; the block buffer itself needs no clearing.
module sha256_stream_hasher (
    input  logic        clk,
    input  logic        rst_n,
    sha_stream_if.sink   msg,
    sha_stream_if.source digest
);

    sha_pkg::sha_cmd_t    cmd;
    sha_pkg::sha_status_t status;
    sha_pkg::msg_req_t    msg_req;
    sha_pkg::digest_req_t digest_req;

    assign msg_req        = msg.payload;
    assign digest.payload = digest_req;

    // Sequencing and both handshakes live in the controller.
    sha_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (msg.valid),
        .in_action (msg_req.action),
        .in_ready  (msg.ready),
        .out_valid (digest.valid),
        .out_ready (digest.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // All hashing state and the digest register live in the datapath.
    sha_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .data_byte (msg_req.data_byte),
        .status    (status),
        .digest    (digest_req)
    );

endmodule

>>> rtl/core/sha_ctrl.sv
// Sequencer for byte intake, padding, the 64 compression rounds and digest delivery.
module sha_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_action,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  sha_pkg::sha_status_t status,
    output sha_pkg::sha_cmd_t    cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ROUND,
        S_UPDATE,
        S_LEN
    } state_t;

    state_t     state_reg, state_next;
    logic [5:0] round_reg, round_next;
    logic       fin_reg, fin_next;
    logic       len_pend_reg, len_pend_next;
    logic       out_valid_reg, out_valid_next;
    logic       in_fire;

    // A finish has to wait until the previous digest is taken; bytes do not.
    assign in_ready  = (state_reg == S_IDLE) && !(in_action && out_valid_reg);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        round_next     = round_reg;
        fin_next       = fin_reg;
        len_pend_next  = len_pend_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        cmd.round_idx  = round_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire && !in_action)
                begin
                    cmd.write_byte = 1'b1;
                    if (status.pos_last)
                    begin
                        cmd.load_work = 1'b1;
                        round_next    = '0;
                        fin_next      = 1'b0;
                        state_next    = S_ROUND;
                    end
                end
                else if (in_fire)
                begin
                    // The length goes into this block unless the pad byte ran past it.
                    cmd.pad       = 1'b1;
                    cmd.len       = !status.pos_ge56;
                    cmd.load_work = 1'b1;
                    round_next    = '0;
                    fin_next      = 1'b1;
                    len_pend_next = status.pos_ge56;
                    state_next    = S_ROUND;
                end
            end
            S_ROUND:
            begin
                cmd.round  = 1'b1;
                round_next = round_reg + 6'd1;
                if (round_reg == 6'(sha_pkg::ROUNDS - 1))
                begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                cmd.update = 1'b1;
                if (fin_reg && len_pend_reg)
                begin
                    len_pend_next = 1'b0;
                    state_next    = S_LEN;
                end
                else
                begin
                    if (fin_reg)
                    begin
                        cmd.emit       = 1'b1;
                        out_valid_next = 1'b1;
                        fin_next       = 1'b0;
                    end
                    state_next = S_IDLE;
                end
            end
            S_LEN:
            begin
                cmd.len       = 1'b1;
                cmd.load_work = 1'b1;
                round_next    = '0;
                state_next    = S_ROUND;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            round_reg     <= '0;
            fin_reg       <= 1'b0;
            len_pend_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            round_reg     <= round_next;
            fin_reg       <= fin_next;
            len_pend_reg  <= len_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_emit_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !out_valid_reg)
        else $error("digest emitted while the previous one is still pending");

    a_round_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROUND) && (round_reg == 6'(sha_pkg::ROUNDS - 1))
        |=> (state_reg == S_UPDATE))
        else $error("last round did not lead to the hash update");

    a_finish_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && in_action |=> (state_reg == S_ROUND) && (round_reg == 6'd0) && fin_reg)
        else $error("finish request did not start a compression");

    a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_UPDATE) && !fin_reg)
        else $error("digest became valid outside the final update");

endmodule

>>> rtl/core/sha_datapath.sv
// Block buffer, message schedule, round registers, chaining hash and digest register.
module sha_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sha_pkg::sha_cmd_t    cmd,
    input  logic [7:0]           data_byte,
    output sha_pkg::sha_status_t status,
    output sha_pkg::digest_req_t digest
);

    logic [31:0] blk_reg  [sha_pkg::BLOCK_WORDS];
    logic [31:0] blk_next [sha_pkg::BLOCK_WORDS];
    logic [31:0] work_reg  [sha_pkg::HASH_WORDS];
    logic [31:0] work_next [sha_pkg::HASH_WORDS];
    logic [31:0] hash_reg  [sha_pkg::HASH_WORDS];
    logic [31:0] hash_next [sha_pkg::HASH_WORDS];
    logic [31:0] hash_sum  [sha_pkg::HASH_WORDS];
    logic [5:0]  pos_reg, pos_next;
    logic [60:0] count_reg, count_next;
    logic        ovf_reg, ovf_next;
    logic [63:0] len_bits;
    logic [31:0] w_new;
    logic [31:0] t1;
    logic [31:0] t2;
    sha_pkg::digest_req_t digest_reg;

    assign status.pos_last = (pos_reg == 6'(sha_pkg::BLOCK_BYTES - 1));
    assign status.pos_ge56 = (pos_reg >= 6'(sha_pkg::LEN_LANE));
    assign len_bits = {count_reg, 3'b000};
    assign digest   = digest_reg;

    // The buffer doubles as the schedule window: word 0 is the current W.
    assign w_new = blk_reg[0] + sha_pkg::small_sigma0(blk_reg[1]) + blk_reg[9]
                 + sha_pkg::small_sigma1(blk_reg[14]);

    assign t1 = work_reg[7] + sha_pkg::big_sigma1(work_reg[4])
              + ((work_reg[4] & work_reg[5]) ^ (~work_reg[4] & work_reg[6]))
              + sha_pkg::ROUND_K[cmd.round_idx] + blk_reg[0];
    assign t2 = sha_pkg::big_sigma0(work_reg[0])
              + ((work_reg[0] & work_reg[1]) ^ (work_reg[0] & work_reg[2])
              ^ (work_reg[1] & work_reg[2]));

    always_comb
    begin
        blk_next = blk_reg;
        for (int p = 0; p < sha_pkg::BLOCK_BYTES; p++)
        begin
            if (cmd.write_byte && (6'(p) == pos_reg))
            begin
                blk_next[4'(p >> 2)][8 * (3 - (p & 3)) +: 8] = data_byte;
            end
            if (cmd.pad && (6'(p) == pos_reg))
            begin
                blk_next[4'(p >> 2)][8 * (3 - (p & 3)) +: 8] = sha_pkg::PAD_BYTE;
            end
            if (cmd.pad && (6'(p) > pos_reg))
            begin
                blk_next[4'(p >> 2)][8 * (3 - (p & 3)) +: 8] = 8'h00;
            end
            // Second block of a finish: all zero apart from the length.
            if (cmd.len && !cmd.pad && (p < sha_pkg::LEN_LANE))
            begin
                blk_next[4'(p >> 2)][8 * (3 - (p & 3)) +: 8] = 8'h00;
            end
        end
        if (cmd.len)
        begin
            blk_next[14] = len_bits[63:32];
            blk_next[15] = len_bits[31:0];
        end
        if (cmd.round)
        begin
            for (int i = 0; i < sha_pkg::BLOCK_WORDS - 1; i++)
            begin
                blk_next[i] = blk_reg[i + 1];
            end
            blk_next[sha_pkg::BLOCK_WORDS - 1] = w_new;
        end
    end

    always_comb
    begin
        work_next = work_reg;
        if (cmd.load_work)
        begin
            work_next = hash_reg;
        end
        else if (cmd.round)
        begin
            work_next[0] = t1 + t2;
            work_next[1] = work_reg[0];
            work_next[2] = work_reg[1];
            work_next[3] = work_reg[2];
            work_next[4] = work_reg[3] + t1;
            work_next[5] = work_reg[4];
            work_next[6] = work_reg[5];
            work_next[7] = work_reg[6];
        end
    end

    always_comb
    begin
        for (int i = 0; i < sha_pkg::HASH_WORDS; i++)
        begin
            hash_sum[i] = hash_reg[i] + work_reg[i];
        end
        hash_next = hash_reg;
        if (cmd.update)
        begin
            if (cmd.emit)
            begin
                hash_next = sha_pkg::INIT_H;
            end
            else
            begin
                hash_next = hash_sum;
            end
        end
    end

    always_comb
    begin
        pos_next   = pos_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (cmd.write_byte)
        begin
            pos_next = pos_reg + 6'd1;
            if (count_reg == sha_pkg::COUNT_MAX)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + 61'd1;
            end
        end
        if (cmd.emit)
        begin
            pos_next   = '0;
            count_next = '0;
            ovf_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg  <= sha_pkg::INIT_H;
            pos_reg   <= '0;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            hash_reg  <= hash_next;
            pos_reg   <= pos_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        blk_reg  <= blk_next;
        work_reg <= work_next;
        if (cmd.emit)
        begin
            digest_reg.digest_word_0 <= hash_sum[0];
            digest_reg.digest_word_1 <= hash_sum[1];
            digest_reg.digest_word_2 <= hash_sum[2];
            digest_reg.digest_word_3 <= hash_sum[3];
            digest_reg.digest_word_4 <= hash_sum[4];
            digest_reg.digest_word_5 <= hash_sum[5];
            digest_reg.digest_word_6 <= hash_sum[6];
            digest_reg.digest_word_7 <= hash_sum[7];
            digest_reg.length_error  <= ovf_reg;
        end
    end

endmodule
